@@ hw/rtl/dci_pkg.sv @@
// Shared types and constants for the dimmer curve interpolator.
package dci_pkg;

    localparam int LEVEL_W = 16;
    localparam int DMX_W   = 8;
    localparam int SLOT_W  = 4;
    localparam int SEG_W   = 4;
    localparam int PCNT_W  = 5;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 16;
    localparam int DIV_CW  = $clog2(LEVEL_W + 1);

    // Fraction T is Q0.16 over 65536, so full scale needs one extra bit.
    localparam logic [LEVEL_W:0]   FRAC_ONE   = 17'd65536;
    localparam logic [LEVEL_W:0]   FRAC_ZERO  = 17'd0;
    localparam logic [LEVEL_W-1:0] MAX_RESET  = 16'hFFFF;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    localparam logic [CFG_AW-1:0] CFG_APPLY_CAL = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_POINT_CNT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_MAX_INT   = 2'd2;

    typedef struct packed {
        logic               command;
        logic [SLOT_W-1:0]  point_index;
        logic [DMX_W-1:0]   point_dmx;
        logic [LEVEL_W-1:0] point_level;
        logic [LEVEL_W-1:0] intensity;
    } t_in_beat;

    typedef struct packed {
        logic [LEVEL_W-1:0] curve_level;
        logic [LEVEL_W-1:0] scaled_intensity;
        logic [SEG_W-1:0]   segment;
    } t_out_beat;

    // One curve point as stored in the memory.
    typedef struct packed {
        logic [DMX_W-1:0]   dmx;
        logic [LEVEL_W-1:0] level;
    } t_point;

    typedef struct packed {
        logic               start;
        logic [LEVEL_W-1:0] num;
        logic [LEVEL_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ hw/rtl/dci_curve_mem.sv @@
// Curve point memory: one write port, one read port, registered read data.
module dci_curve_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  dci_pkg::t_point i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output dci_pkg::t_point o_rdata
);

    dci_pkg::t_point r_mem [DEPTH];
    dci_pkg::t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/dci_divider.sv @@
// Restoring radix-2 divider for the segment fraction, one quotient bit a cycle.
module dci_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dci_pkg::t_div_req i_req,
    output dci_pkg::t_div_rsp o_rsp
);

    localparam int W = dci_pkg::LEVEL_W;

    logic                      r_busy;
    logic [dci_pkg::DIV_CW-1:0] r_cnt;
    logic [W-1:0]              r_rem;
    logic [W-1:0]              r_quot;
    logic [W-1:0]              r_den;

    logic [W:0] step_shift;
    logic       step_fit;
    logic [W:0] step_diff;

    // Numerator is below the divisor, so the remainder stays under W bits.
    always_comb begin
        step_shift = {r_rem, 1'b0};
        step_diff  = step_shift - {1'b0, r_den};
        step_fit   = step_shift >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= dci_pkg::DIV_CW'(W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_rem  <= step_fit ? step_diff[W-1:0] : step_shift[W-1:0];
            r_quot <= {r_quot[W-2:0], step_fit};
        end
    end

    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.quot = r_quot;

endmodule

@@ hw/rtl/dimmer_curve_interpolator_unit.sv @@
// Dimmer curve interpolator top level: sequencer, curve memory, fraction and scale math.
// Load beat: written to the curve memory at the accept edge, no result.
// Convert, linear: straight to the scale state, result registered there once the output is free.
// Curved: walk, fraction, 16-step divider (skipped when the fraction clamps), multiply, add, scale.
// One convert at a time; the output register lets the next beat in while a result waits.
// Synchronous active-low reset clears sequencer, output valid, config; curve memory kept.
module dimmer_curve_interpolator_unit #(
    parameter int MAX_POINTS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [dci_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [dci_pkg::CFG_DW-1:0]         i_cfg_wdata,
    // input beats
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  dci_pkg::t_in_beat                  i_in_data,
    // result beats
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output dci_pkg::t_out_beat                 o_out_data
);

    localparam int LW = dci_pkg::LEVEL_W;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    // Common width for point counts, slots and indexes.
    localparam int NW = (CW > dci_pkg::PCNT_W) ? CW : dci_pkg::PCNT_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_WALK  = 7'b0000010,
        S_FRAC  = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_LMUL  = 7'b0010000,
        S_LADD  = 7'b0100000,
        S_SCALE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic                       r_cal;
    logic [dci_pkg::PCNT_W-1:0] r_pcnt;
    logic [LW-1:0]              r_max;

    // datapath
    logic [LW-1:0]       r_intensity;
    logic [AW-1:0]       r_addr;
    logic [AW-1:0]       r_didx;
    logic                r_dvalid;
    dci_pkg::t_point     r_lo;
    dci_pkg::t_point     r_hi;
    logic [dci_pkg::SEG_W-1:0] r_seg;
    logic [LW:0]         r_t;
    logic signed [2*LW+2:0] r_prod;
    logic [LW-1:0]       r_level;

    dci_pkg::t_out_beat  r_out;
    logic                r_out_valid;

    // handshakes
    logic in_accept;
    logic out_free;
    assign in_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;

    // ---------------------------------------------------------------
    // Curve memory. Loads write at the accept edge; a convert reads only
    // from the next cycle on, so the two never touch an entry together.
    // ---------------------------------------------------------------
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    dci_pkg::t_point mem_wdata;
    dci_pkg::t_point mem_rdata;
    logic [NW-1:0]   slot_x;

    assign slot_x    = NW'(i_in_data.point_index);
    assign mem_we    = in_accept && (i_in_data.command == dci_pkg::CMD_LOAD) &&
                       (slot_x < NW'(MAX_POINTS));
    assign mem_waddr = slot_x[AW-1:0];
    assign mem_wdata = '{dmx: i_in_data.point_dmx, level: i_in_data.point_level};

    dci_curve_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    // ---------------------------------------------------------------
    // Points in use, saturated to the memory depth.
    // ---------------------------------------------------------------
    logic [NW-1:0] pts;
    logic          linear;
    assign pts    = (NW'(r_pcnt) > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(r_pcnt);
    assign linear = !r_cal || (pts < NW'(2));

    // ---------------------------------------------------------------
    // Walk: entry k arrives the cycle after its address. A point p sits at
    // or above the input when p*257 >= intensity (both sides over 65535).
    // ---------------------------------------------------------------
    logic          walk_hit;
    logic          walk_last;
    logic          walk_done;
    logic [NW-1:0] seg_x;
    assign walk_hit  = {mem_rdata.dmx, mem_rdata.dmx} >= r_intensity;
    assign walk_last = NW'(r_didx) == (pts - NW'(1));
    assign walk_done = r_dvalid && (r_didx != '0) && (walk_hit || walk_last);
    assign seg_x     = NW'(r_didx) - NW'(1);

    // ---------------------------------------------------------------
    // Fraction setup: the common 65535 scale is cancelled, so
    // T = (intensity - lo*257) * 65536 / ((hi - lo) * 257), sign folded.
    // ---------------------------------------------------------------
    logic signed [dci_pkg::DMX_W:0] f_dd;
    logic signed [LW+1:0]           f_nn;
    logic signed [LW+1:0]           f_an;
    logic signed [dci_pkg::DMX_W:0] f_neg_dd;
    logic [dci_pkg::DMX_W-1:0]      f_ad;
    logic [LW-1:0]                  f_den;
    logic                           f_zero;
    logic                           f_full;

    always_comb begin
        f_dd     = $signed({1'b0, r_hi.dmx}) - $signed({1'b0, r_lo.dmx});
        f_nn     = $signed({2'b00, r_intensity}) - $signed({2'b00, r_lo.dmx, r_lo.dmx});
        f_neg_dd = -f_dd;
        f_ad     = f_dd[dci_pkg::DMX_W] ? f_neg_dd[dci_pkg::DMX_W-1:0]
                                        : f_dd[dci_pkg::DMX_W-1:0];
        f_an     = f_dd[dci_pkg::DMX_W] ? -f_nn : f_nn;
        f_den    = {f_ad, f_ad};
        // zero-width segment takes the lower level
        f_zero   = (f_dd == '0) || f_an[LW+1] || (f_an == '0);
        f_full   = f_an >= $signed({2'b00, f_den});
    end

    dci_pkg::t_div_req div_req;
    dci_pkg::t_div_rsp div_rsp;

    assign div_req.start = (r_state == S_FRAC) && !f_zero && !f_full;
    assign div_req.num   = f_an[LW-1:0];
    assign div_req.den   = f_den;

    dci_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------------------------------------------------------
    // Interpolation: lo + ((hi - lo) * T + half) >> 16, then the scale.
    // ---------------------------------------------------------------
    logic signed [LW:0]     l_diff;
    logic signed [LW+1:0]   l_t;
    logic signed [2*LW+2:0] l_sum;
    logic signed [2*LW+2:0] l_sh;
    logic [2*LW-1:0]        s_prod;

    always_comb begin
        l_diff = $signed({1'b0, r_hi.level}) - $signed({1'b0, r_lo.level});
        l_t    = $signed({1'b0, r_t});
        l_sum  = r_prod + $signed((2*LW+3)'(1 << (LW - 1)));
        l_sh   = l_sum >>> LW;
        s_prod = r_level * r_max;
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && i_in_data.command == dci_pkg::CMD_CONVERT) begin
                    n_state = linear ? S_SCALE : S_WALK;
                end
            end
            S_WALK: begin
                if (walk_done) begin
                    n_state = S_FRAC;
                end
            end
            S_FRAC: begin
                n_state = div_req.start ? S_DIV : S_LMUL;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_LMUL;
                end
            end
            S_LMUL:  n_state = S_LADD;
            S_LADD:  n_state = S_SCALE;
            S_SCALE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_dvalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SCALE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_dvalid <= (r_state == S_WALK) && !walk_done;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal  <= 1'b0;
            r_pcnt <= '0;
            r_max  <= dci_pkg::MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                dci_pkg::CFG_APPLY_CAL: r_cal  <= i_cfg_wdata[0];
                dci_pkg::CFG_POINT_CNT: r_pcnt <= i_cfg_wdata[dci_pkg::PCNT_W-1:0];
                dci_pkg::CFG_MAX_INT:   r_max  <= i_cfg_wdata[LW-1:0];
                default: ;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_addr <= '0;
                if (in_accept) begin
                    r_intensity <= i_in_data.intensity;
                    r_level     <= i_in_data.intensity;
                    r_seg       <= '0;
                end
            end
            S_WALK: begin
                r_addr <= r_addr + 1'b1;
                r_didx <= r_addr;
                if (r_dvalid) begin
                    if (walk_done) begin
                        r_hi  <= mem_rdata;
                        r_seg <= seg_x[dci_pkg::SEG_W-1:0];
                    end else begin
                        r_lo <= mem_rdata;
                    end
                end
            end
            S_FRAC: begin
                r_t <= f_zero ? dci_pkg::FRAC_ZERO : dci_pkg::FRAC_ONE;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    r_t <= {1'b0, div_rsp.quot};
                end
            end
            S_LMUL: begin
                r_prod <= l_diff * l_t;
            end
            S_LADD: begin
                r_level <= r_lo.level + l_sh[LW-1:0];
            end
            S_SCALE: begin
                if (out_free) begin
                    r_out.curve_level      <= r_level;
                    r_out.scaled_intensity <= s_prod[2*LW-1:LW];
                    r_out.segment          <= r_seg;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ hw/rtl/dci_checker.sv @@
// Port-level checker for the dimmer curve interpolator, bound to the top level.
module dci_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input dci_pkg::t_in_beat  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input dci_pkg::t_out_beat o_out_data
);

    // A stalled result holds its beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // A convert occupies the block for at least the next cycle.
    a_convert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.command == dci_pkg::CMD_CONVERT
        |=> !o_in_ready)
        else $error("input ready right after a convert beat");

    // A load completes in its accept cycle.
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.command == dci_pkg::CMD_LOAD
        |=> o_in_ready && !$rose(o_out_valid))
        else $error("load beat stalled input or produced a result");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind dimmer_curve_interpolator_unit dci_checker u_dci_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
